FILE: rtl/core/bale_pkg.sv
// Shared types, codes and defaults for the bounded array list engine.
package bale_pkg;

    // Default sizes of the list.
    localparam int CAPACITY_DEF   = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    // Width of positions and counts broadcast to the cells (covers up to 1024 entries).
    localparam int CTL_W = 11;

    // Command codes.
    localparam logic [3:0] CMD_APPEND    = 4'd0;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd1;
    localparam logic [3:0] CMD_INS_AFTER = 4'd2;
    localparam logic [3:0] CMD_DELETE    = 4'd3;
    localparam logic [3:0] CMD_SEARCH    = 4'd4;
    localparam logic [3:0] CMD_READ      = 4'd5;
    localparam logic [3:0] CMD_REVERSE   = 4'd6;
    localparam logic [3:0] CMD_SORT      = 4'd7;
    localparam logic [3:0] CMD_DEDUP     = 4'd8;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BAD_POS   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Operation applied by every cell together.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TAG,
        OP_INSERT,
        OP_CLOSE,
        OP_ROTATE,
        OP_PROBE,
        OP_SORT
    } cell_op_t;

    // Ordering key used by the compare-exchange network.
    typedef enum logic [1:0] {
        KEY_VALUE,
        KEY_REVERSE,
        KEY_DEDUP
    } sort_key_t;

    // Control broadcast from the sequencer to the row of cells.
    typedef struct packed {
        cell_op_t         op;
        sort_key_t        key;
        logic             phase;
        logic [CTL_W-1:0] at;
        logic [CTL_W-1:0] cnt;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PROBE,
        S_COUNT,
        S_SORT,
        S_DONE
    } state_t;

endpackage

FILE: rtl/core/bounded_array_list_engine.sv
// Top level: command sequencer driving a row of list cells.
// Append, insert, delete and error results go from decode straight to the result state.
// Search and read walk a full rotation of the cell row before the result.
// Sort and reverse run an odd-even exchange pass; dedup runs a probe, a count and a sort pass.
// One item is in work at a time; the next is taken after its result is delivered.
// Reset clears the count and sequencer; the cell entries are not cleared.
module bounded_array_list_engine #(
    parameter int CAPACITY   = bale_pkg::CAPACITY_DEF,
    parameter int ITEM_WIDTH = bale_pkg::ITEM_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         command,
    input  logic [5:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [5:0]         found_index,
    output logic signed [31:0] read_value,
    output logic [6:0]         count
);

    localparam int IW = ITEM_WIDTH;
    localparam int TW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [TW-1:0] LAST = TW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    bale_pkg::state_t    state_reg, state_next;
    bale_pkg::sort_key_t key_reg, key_next;
    bale_pkg::cell_ctl_t ctl;

    logic [TW-1:0] step_reg, step_next;
    logic [3:0]    cmd_reg, cmd_next;
    logic [5:0]    pos_reg, pos_next;
    logic [IW-1:0] item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [2:0]    status_reg, status_next;
    logic [TW-1:0] found_reg, found_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] rd_reg, rd_next;

    logic signed [63:0] value_wide;
    logic signed [63:0] rd_wide;
    logic [bale_pkg::CTL_W-1:0] pos_ext, cnt_ext, step_ext;
    logic full;

    logic [IW-1:0] cval [CAPACITY];
    logic [TW-1:0] ctag [CAPACITY];
    logic          cdup [CAPACITY];
    logic [IW-1:0] cpval [CAPACITY];
    logic          cpok [CAPACITY];

    // Row of cells; the last cell's right neighbor is the first, closing the rotation ring.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [IW-1:0] lv, lpv;
        logic [TW-1:0] lt;
        logic          ld, lpo;
        if (i == 0)
        begin : g_first
            assign lv  = '0;
            assign lt  = '0;
            assign ld  = 1'b0;
            assign lpv = '0;
            assign lpo = 1'b0;
        end
        else
        begin : g_rest
            assign lv  = cval[i-1];
            assign lt  = ctag[i-1];
            assign ld  = cdup[i-1];
            assign lpv = cpval[i-1];
            assign lpo = cpok[i-1];
        end
        bale_cell #(
            .IW  (IW),
            .TW  (TW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .ins_value (item_reg),
            .left_val  (lv),
            .left_tag  (lt),
            .left_dup  (ld),
            .left_pval (lpv),
            .left_pok  (lpo),
            .right_val (cval[(i + 1) % CAPACITY]),
            .right_tag (ctag[(i + 1) % CAPACITY]),
            .right_dup (cdup[(i + 1) % CAPACITY]),
            .val       (cval[i]),
            .tag       (ctag[i]),
            .dup       (cdup[i]),
            .pval      (cpval[i]),
            .pok       (cpok[i])
        );
    end

    // Input value sign extended, then kept in the entry width.
    assign value_wide = 64'(value);
    assign pos_ext    = bale_pkg::CTL_W'(pos_reg);
    assign cnt_ext    = bale_pkg::CTL_W'(count_reg);
    assign step_ext   = bale_pkg::CTL_W'(step_reg);
    assign full       = (count_reg == FULL_CNT);

    // Sequencer: decode, long walks over the cell row, and result hold.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        kept_next   = kept_reg;
        status_next = status_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        rd_next     = rd_reg;
        key_next    = key_reg;
        ctl.op      = bale_pkg::OP_HOLD;
        ctl.key     = key_reg;
        ctl.phase   = step_reg[0];
        ctl.at      = pos_ext;
        ctl.cnt     = cnt_ext;
        unique case (state_reg)
            bale_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = command;
                    pos_next    = position;
                    item_next   = value_wide[IW-1:0];
                    status_next = bale_pkg::ST_OK;
                    found_next  = '0;
                    hit_next    = 1'b0;
                    rd_next     = '0;
                    step_next   = '0;
                    kept_next   = '0;
                    state_next  = bale_pkg::S_DECODE;
                end
            end
            bale_pkg::S_DECODE:
            begin
                state_next = bale_pkg::S_DONE;
                case (cmd_reg)
                    bale_pkg::CMD_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.op     = bale_pkg::OP_INSERT;
                            ctl.at     = cnt_ext;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bale_pkg::CMD_INS_BEFORE:
                    begin
                        if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else if (pos_ext > cnt_ext)
                        begin
                            status_next = bale_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            ctl.op     = bale_pkg::OP_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bale_pkg::CMD_INS_AFTER:
                    begin
                        if (full)
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            status_next = bale_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            ctl.op     = bale_pkg::OP_INSERT;
                            ctl.at     = pos_ext + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bale_pkg::CMD_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            status_next = bale_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            ctl.op     = bale_pkg::OP_CLOSE;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    bale_pkg::CMD_SEARCH:
                    begin
                        status_next = bale_pkg::ST_NOT_FOUND;
                        state_next  = bale_pkg::S_SCAN;
                    end
                    bale_pkg::CMD_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            status_next = bale_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            state_next = bale_pkg::S_SCAN;
                        end
                    end
                    bale_pkg::CMD_REVERSE:
                    begin
                        ctl.op     = bale_pkg::OP_TAG;
                        key_next   = bale_pkg::KEY_REVERSE;
                        state_next = bale_pkg::S_SORT;
                    end
                    bale_pkg::CMD_SORT:
                    begin
                        key_next   = bale_pkg::KEY_VALUE;
                        state_next = bale_pkg::S_SORT;
                    end
                    bale_pkg::CMD_DEDUP:
                    begin
                        ctl.op     = bale_pkg::OP_TAG;
                        key_next   = bale_pkg::KEY_DEDUP;
                        state_next = bale_pkg::S_PROBE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            bale_pkg::S_SCAN:
            begin
                // The first cell holds entry number step during the rotation.
                ctl.op    = bale_pkg::OP_ROTATE;
                step_next = step_reg + 1'b1;
                if ((cmd_reg == bale_pkg::CMD_SEARCH) && !hit_reg && (step_ext < cnt_ext)
                    && (cval[0] == item_reg))
                begin
                    hit_next    = 1'b1;
                    found_next  = step_reg;
                    status_next = bale_pkg::ST_OK;
                end
                if ((cmd_reg == bale_pkg::CMD_READ) && (step_ext == pos_ext))
                begin
                    rd_next = cval[0];
                end
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = bale_pkg::S_DONE;
                end
            end
            bale_pkg::S_PROBE:
            begin
                // Copies of the entries slide right so each cell meets every earlier entry.
                ctl.op    = bale_pkg::OP_PROBE;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = bale_pkg::S_COUNT;
                end
            end
            bale_pkg::S_COUNT:
            begin
                // Count the first occurrences as the duplicate marks pass the first cell.
                ctl.op    = bale_pkg::OP_ROTATE;
                step_next = step_reg + 1'b1;
                if ((step_ext < cnt_ext) && !cdup[0])
                begin
                    kept_next = kept_reg + 1'b1;
                end
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = bale_pkg::S_SORT;
                end
            end
            bale_pkg::S_SORT:
            begin
                ctl.op    = bale_pkg::OP_SORT;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = bale_pkg::S_DONE;
                    if (cmd_reg == bale_pkg::CMD_DEDUP)
                    begin
                        count_next = kept_reg;
                    end
                end
            end
            bale_pkg::S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = bale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bale_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bale_pkg::S_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        kept_reg   <= kept_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        hit_reg    <= hit_next;
        rd_reg     <= rd_next;
        key_reg    <= key_next;
    end

    // Result ports.
    assign rd_wide     = 64'($signed(rd_reg));
    assign in_stall    = (state_reg != bale_pkg::S_IDLE);
    assign out_valid   = (state_reg == bale_pkg::S_DONE);
    assign status      = status_reg;
    assign found_index = 6'(found_reg);
    assign read_value  = rd_wide[31:0];
    assign count       = 7'(count_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("list count above capacity");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bale_pkg::S_IDLE) && in_valid |=> (state_reg == bale_pkg::S_DECODE))
        else $error("accepted item not decoded");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bale_pkg::S_SCAN) && (step_reg == LAST)
        |=> (state_reg == bale_pkg::S_DONE) && (step_reg == '0))
        else $error("scan did not finish after a full rotation");
`endif

endmodule

FILE: rtl/core/bale_cell.sv
// One list cell: holds an entry, its tag and duplicate mark, and trades with its neighbors.
module bale_cell #(
    parameter int IW  = bale_pkg::ITEM_WIDTH_DEF,
    parameter int TW  = 6,
    parameter int IDX = 0
) (
    input  logic                clk,
    input  bale_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]       ins_value,
    input  logic [IW-1:0]       left_val,
    input  logic [TW-1:0]       left_tag,
    input  logic                left_dup,
    input  logic [IW-1:0]       left_pval,
    input  logic                left_pok,
    input  logic [IW-1:0]       right_val,
    input  logic [TW-1:0]       right_tag,
    input  logic                right_dup,
    output logic [IW-1:0]       val,
    output logic [TW-1:0]       tag,
    output logic                dup,
    output logic [IW-1:0]       pval,
    output logic                pok
);

    localparam logic [bale_pkg::CTL_W-1:0] MY = bale_pkg::CTL_W'(IDX);

    logic [IW-1:0] val_reg, val_next;
    logic [TW-1:0] tag_reg, tag_next;
    logic          dup_reg, dup_next;
    logic [IW-1:0] pval_reg, pval_next;
    logic          pok_reg, pok_next;
    logic          lead, trail, swap_right, swap_left;

    // True when entry a must move behind entry b under the active key.
    function automatic logic after_fn(input bale_pkg::sort_key_t key,
                                      input logic [IW-1:0] av, input logic [TW-1:0] at,
                                      input logic ad,
                                      input logic [IW-1:0] bv, input logic [TW-1:0] bt,
                                      input logic bd);
        logic r;
        case (key)
            bale_pkg::KEY_VALUE:   r = $signed(av) > $signed(bv);
            bale_pkg::KEY_REVERSE: r = at < bt;
            default:               r = {ad, at} > {bd, bt};
        endcase
        return r;
    endfunction

    // Pairing of the odd-even exchange among the live entries.
    always_comb
    begin
        lead  = (MY[0] == ctl.phase) && ((MY + 1'b1) < ctl.cnt);
        trail = (IDX >= 1) && (MY[0] != ctl.phase) && (MY < ctl.cnt);
        swap_right = lead && after_fn(ctl.key, val_reg, tag_reg, dup_reg,
                                      right_val, right_tag, right_dup);
        swap_left  = trail && after_fn(ctl.key, left_val, left_tag, left_dup,
                                       val_reg, tag_reg, dup_reg);
    end

    // Next cell contents for each operation.
    always_comb
    begin
        val_next  = val_reg;
        tag_next  = tag_reg;
        dup_next  = dup_reg;
        pval_next = pval_reg;
        pok_next  = pok_reg;
        unique case (ctl.op)
            bale_pkg::OP_TAG:
            begin
                tag_next  = TW'(IDX);
                dup_next  = 1'b0;
                pval_next = val_reg;
                pok_next  = 1'b1;
            end
            bale_pkg::OP_INSERT:
            begin
                if (MY == ctl.at)
                begin
                    val_next = ins_value;
                end
                else if ((MY > ctl.at) && (MY <= ctl.cnt))
                begin
                    val_next = left_val;
                end
            end
            bale_pkg::OP_CLOSE:
            begin
                if ((MY >= ctl.at) && ((MY + 1'b1) < ctl.cnt))
                begin
                    val_next = right_val;
                end
            end
            bale_pkg::OP_ROTATE:
            begin
                val_next = right_val;
                tag_next = right_tag;
                dup_next = right_dup;
            end
            bale_pkg::OP_PROBE:
            begin
                pval_next = left_pval;
                pok_next  = left_pok;
                if (left_pok && (left_pval == val_reg) && (MY < ctl.cnt))
                begin
                    dup_next = 1'b1;
                end
            end
            bale_pkg::OP_SORT:
            begin
                if (swap_right)
                begin
                    val_next = right_val;
                    tag_next = right_tag;
                    dup_next = right_dup;
                end
                else if (swap_left)
                begin
                    val_next = left_val;
                    tag_next = left_tag;
                    dup_next = left_dup;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Cell storage.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        tag_reg  <= tag_next;
        dup_reg  <= dup_next;
        pval_reg <= pval_next;
        pok_reg  <= pok_next;
    end

    assign val  = val_reg;
    assign tag  = tag_reg;
    assign dup  = dup_reg;
    assign pval = pval_reg;
    assign pok  = pok_reg;

endmodule
